FILE: rtl/core/mbrc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the
// Modbus RTU response checker. No dependencies.
package mbrc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] RST_SLAVE     = 8'd1;
    localparam logic [6:0] RST_FUNCTION  = 7'd3;
    localparam logic [6:0] RST_REGISTERS = 7'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE     = 2'd0,
        CFG_FUNCTION  = 2'd1,
        CFG_REGISTERS = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_BAD = 2'd1,
        ST_HDR_BAD = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] slave;
        logic [6:0] function_code;
        logic [6:0] registers;
    } t_cfg;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_done;
        t_status    frame_status;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/mbrc_if.sv
// Channel interfaces for the Modbus RTU response checker: byte input,
// result output and configuration write. Depends on mbrc_pkg.
interface mbrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface mbrc_out_if;
    logic                 valid;
    logic                 ready;
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic                 frame_done;
    mbrc_pkg::t_status    frame_status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_done, output frame_status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input frame_done, input frame_status, output ready);
endinterface

interface mbrc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mbrc_pkg::CFG_IDX_W-1:0]  index;
    logic [mbrc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mbrc_frame_core.sv
// Per-frame state of the checker: byte index, two-byte delay line, running
// CRC and header flag, with the result for the byte being processed.
// Depends on mbrc_pkg.
module mbrc_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_eof,
    input  mbrc_pkg::t_cfg    i_cfg,
    output logic              o_has_result,
    output mbrc_pkg::t_result o_result
);

    logic [mbrc_pkg::IDX_W-1:0] r_byte_index, n_byte_index;
    logic [15:0]                r_crc, n_crc;
    logic [7:0]                 r_delay0, n_delay0;
    logic [7:0]                 r_delay1, n_delay1;
    logic                       r_header, n_header;

    logic                       w_ovf;
    logic [7:0]                 w_count;
    logic                       w_hdr_now;
    logic [15:0]                w_crc_new;
    logic [mbrc_pkg::IDX_W-1:0] w_pos;
    logic [mbrc_pkg::IDX_W-1:0] w_pos_off;
    logic                       w_pv;
    logic                       w_crc_ok;
    mbrc_pkg::t_status          w_status;

    always_comb begin
        w_ovf   = r_byte_index >= mbrc_pkg::IDX_W'(mbrc_pkg::MAX_FRAME_BYTES);
        w_count = {i_cfg.registers, 1'b0};

        w_hdr_now = r_header;
        if (r_byte_index == mbrc_pkg::IDX_W'(0) && i_rx_byte != i_cfg.slave) begin
            w_hdr_now = 1'b0;
        end
        if (r_byte_index == mbrc_pkg::IDX_W'(1) && i_rx_byte != {1'b0, i_cfg.function_code}) begin
            w_hdr_now = 1'b0;
        end
        if (r_byte_index == mbrc_pkg::IDX_W'(2) && i_rx_byte != w_count) begin
            w_hdr_now = 1'b0;
        end

        if (r_byte_index >= mbrc_pkg::IDX_W'(2)) begin
            w_crc_new = mbrc_pkg::crc_feed(r_crc, r_delay0);
        end else begin
            w_crc_new = r_crc;
        end

        w_pos     = r_byte_index - mbrc_pkg::IDX_W'(2);
        w_pos_off = w_pos - mbrc_pkg::IDX_W'(3);
        w_pv      = !w_ovf && (r_byte_index >= mbrc_pkg::IDX_W'(2))
                    && (w_pos >= mbrc_pkg::IDX_W'(3))
                    && (w_pos_off < mbrc_pkg::IDX_W'(w_count));

        w_crc_ok = (w_crc_new[7:0] == r_delay1) && (w_crc_new[15:8] == i_rx_byte);

        if (w_ovf || r_byte_index < mbrc_pkg::IDX_W'(4)) begin
            w_status = mbrc_pkg::ST_BAD_LEN;
        end else if (!w_crc_ok) begin
            w_status = mbrc_pkg::ST_CRC_BAD;
        end else if (!w_hdr_now) begin
            w_status = mbrc_pkg::ST_HDR_BAD;
        end else begin
            w_status = mbrc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_has_result           = w_pv || i_eof;
        o_result.payload_valid = w_pv;
        o_result.payload_byte  = w_pv ? r_delay0 : 8'h00;
        o_result.frame_done    = i_eof;
        o_result.frame_status  = i_eof ? w_status : mbrc_pkg::ST_OK;
    end

    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_delay0     = r_delay0;
        n_delay1     = r_delay1;
        n_header     = r_header;
        if (i_fire) begin
            if (i_eof) begin
                n_byte_index = '0;
                n_crc        = mbrc_pkg::CRC_INIT;
                n_delay0     = 8'h00;
                n_delay1     = 8'h00;
                n_header     = 1'b1;
            end else if (!w_ovf) begin
                n_byte_index = r_byte_index + mbrc_pkg::IDX_W'(1);
                n_crc        = w_crc_new;
                n_delay0     = r_delay1;
                n_delay1     = i_rx_byte;
                n_header     = w_hdr_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= mbrc_pkg::CRC_INIT;
            r_delay0     <= 8'h00;
            r_delay1     <= 8'h00;
            r_header     <= 1'b1;
        end else begin
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_delay0     <= n_delay0;
            r_delay1     <= n_delay1;
            r_header     <= n_header;
        end
    end

    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= mbrc_pkg::IDX_W'(mbrc_pkg::MAX_FRAME_BYTES))
        else $error("byte index ran past the frame limit");

    a_clear_after_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_eof |=> r_byte_index == '0 && r_crc == mbrc_pkg::CRC_INIT && r_header)
        else $error("frame state not cleared after the last byte");

    a_no_payload_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ovf |-> !w_pv)
        else $error("payload released past the frame limit");

endmodule

FILE: rtl/core/modbus_rtu_response_checker_unit.sv
// Top level of the Modbus RTU read-holding-registers response checker.
// Holds the configuration registers, the input and result registers, and
// instantiates mbrc_frame_core. Depends on mbrc_pkg and mbrc_if.
//
// Usage: received response bytes enter on i_in, one per transfer, with
// end_of_frame set on the last byte. The block checks slave address,
// function code and byte count, runs CRC-16/MODBUS over all but the last
// two bytes, and emits a result on o_out for each released register data
// byte and for the last byte of the frame (frame_done with frame_status).
// A consumer discards the frame's payload unless frame_status is ok.
// Configuration registers are to be written on i_cfg only while no frame is
// in flight; the block does not enforce this. That channel is always ready.
// Timing: a byte enters the input register at its transfer edge and its
// result is loaded from the input register into the result register,
// from which it transfers on o_out. Throughput is one byte per cycle while
// o_out does not stall, set by the single CRC byte step between the input
// and result registers. When o_out stalls, the input register still takes
// one more byte; that byte and all later ones wait, even bytes that make no
// result. Reset restores the configuration defaults (slave 1, function 3,
// one register) and clears all frame state.
module modbus_rtu_response_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbrc_in_if.sink     i_in,
    mbrc_out_if.source  o_out,
    mbrc_cfg_if.sink    i_cfg
);

    mbrc_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eof;
    logic              r_out_valid;
    mbrc_pkg::t_result r_out;

    logic              w_proceed;
    logic              w_has_result;
    mbrc_pkg::t_result w_result;

    assign w_proceed  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_proceed;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave         <= mbrc_pkg::RST_SLAVE;
            r_cfg.function_code <= mbrc_pkg::RST_FUNCTION;
            r_cfg.registers     <= mbrc_pkg::RST_REGISTERS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mbrc_pkg::CFG_SLAVE:     r_cfg.slave         <= i_cfg.data;
                mbrc_pkg::CFG_FUNCTION:  r_cfg.function_code <= i_cfg.data[6:0];
                mbrc_pkg::CFG_REGISTERS: r_cfg.registers     <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
            r_in_eof  <= i_in.end_of_frame;
        end
    end

    mbrc_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_proceed),
        .i_rx_byte    (r_in_byte),
        .i_eof        (r_in_eof),
        .i_cfg        (r_cfg),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.frame_done    = r_out.frame_done;
    assign o_out.frame_status  = r_out.frame_status;

    a_result_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.payload_valid || r_out.frame_done)
        else $error("empty result presented");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_done |-> r_out.frame_status == mbrc_pkg::ST_OK)
        else $error("status set on a result that does not end the frame");

    a_byte_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.payload_valid |-> r_out.payload_byte == 8'h00)
        else $error("payload byte set without payload valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !w_proceed)
        else $error("byte processed while a result is held");

endmodule

FILE: tb/modbus_rtu_response_checker_unit_test.sv
// Self-checking testbench for modbus_rtu_response_checker_unit. It streams Modbus RTU
// responses under several register settings and compares every released payload byte and
// frame status with a byte-level predictor. Depends on mbrc_pkg, mbrc_if and the RTL.
`timescale 1ns / 1ps

module modbus_rtu_response_checker_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 250;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rx_item;

    typedef struct packed {
        mbrc_pkg::t_cfg_reg index;
        logic [7:0]         data;
    } t_reg_write;

    typedef enum int {
        FR_GOOD, FR_BAD_CRC, FR_BAD_SLAVE, FR_BAD_FUNC, FR_BAD_COUNT,
        FR_SHORT, FR_CUT, FR_EXTRA, FR_NOISE, FR_LONG
    } t_frame_kind;

    logic i_clk;
    logic i_rst_n;

    mbrc_in_if  in_ch ();
    mbrc_out_if out_ch ();
    mbrc_cfg_if cfg_ch ();

    modbus_rtu_response_checker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_rx_item          rx_byte_q[$];
    t_reg_write        reg_write_q[$];
    mbrc_pkg::t_result payload_status_q[$];

    logic [7:0]  exp_slave     = mbrc_pkg::RST_SLAVE;
    logic [6:0]  exp_function  = mbrc_pkg::RST_FUNCTION;
    logic [6:0]  exp_registers = mbrc_pkg::RST_REGISTERS;

    int          resp_index    = 0;
    logic [15:0] resp_crc      = mbrc_pkg::CRC_INIT;
    logic [7:0]  resp_delay[2] = '{8'h00, 8'h00};
    bit          resp_hdr_ok   = 1'b1;
    bit          resp_overflow = 1'b0;

    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int tx_wait;
    int rx_wait;
    bit rx_hold = 1'b0;

    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int payload_seen = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int bytes_accepted = 0;
    int stim_bytes = 0;
    int frames_queued = 0;
    int settings_used = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ data[i];
            acc = {1'b0, acc[15:1]} ^ (fb ? mbrc_pkg::CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic logic [15:0] frame_crc(input logic [7:0] body[$]);
        logic [15:0] crc;
        crc = mbrc_pkg::CRC_INIT;
        foreach (body[i]) crc = crc16_modbus_step(crc, body[i]);
        return crc;
    endfunction

    function automatic int pick_delay(input int max_gap);
        return $urandom_range(0, max_gap);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_checked, what, got, want);
        end
    endtask

    // Frame state advances once per accepted byte; the two newest bytes wait in the
    // delay line because they may turn out to be the CRC.
    task automatic track_response_byte(input logic [7:0] rx, input logic last);
        mbrc_pkg::t_result res;
        logic [7:0]        count;
        int                area_pos;
        res.payload_valid = 1'b0;
        res.payload_byte  = 8'h00;
        res.frame_done    = last;
        res.frame_status  = mbrc_pkg::ST_OK;
        count = {exp_registers, 1'b0};
        if (resp_index >= mbrc_pkg::MAX_FRAME_BYTES) begin
            resp_overflow = 1'b1;
        end else begin
            if (resp_index == 0 && rx != exp_slave) resp_hdr_ok = 1'b0;
            if (resp_index == 1 && rx != {1'b0, exp_function}) resp_hdr_ok = 1'b0;
            if (resp_index == 2 && rx != count) resp_hdr_ok = 1'b0;
            if (resp_index >= 2) begin
                resp_crc = crc16_modbus_step(resp_crc, resp_delay[0]);
                area_pos = resp_index - 2;
                if (area_pos >= 3 && area_pos < 3 + int'(count)) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = resp_delay[0];
                end
            end
            if (last) begin
                if (resp_index + 1 < 5) begin
                    res.frame_status = mbrc_pkg::ST_BAD_LEN;
                end else if ({rx, resp_delay[1]} != resp_crc) begin
                    res.frame_status = mbrc_pkg::ST_CRC_BAD;
                end else if (!resp_hdr_ok) begin
                    res.frame_status = mbrc_pkg::ST_HDR_BAD;
                end
            end
            resp_delay[0] = resp_delay[1];
            resp_delay[1] = rx;
            resp_index++;
        end
        if (last && resp_overflow) res.frame_status = mbrc_pkg::ST_BAD_LEN;
        if (res.payload_valid || last) payload_status_q.push_back(res);
        if (last) begin
            resp_index    = 0;
            resp_crc      = mbrc_pkg::CRC_INIT;
            resp_delay[0] = 8'h00;
            resp_delay[1] = 8'h00;
            resp_hdr_ok   = 1'b1;
            resp_overflow = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_rx_item item;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                track_response_byte(in_ch.rx_byte, in_ch.end_of_frame);
                bytes_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_wait > 0) begin
                    tx_wait <= tx_wait - 1;
                    in_ch.valid <= 1'b0;
                end else if (rx_byte_q.size() > 0) begin
                    item = rx_byte_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.rx_byte <= item.data;
                    in_ch.end_of_frame <= item.last;
                    tx_wait <= pick_delay(tx_gap_max);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_reg_write w;
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    mbrc_pkg::CFG_SLAVE:     exp_slave = cfg_ch.data;
                    mbrc_pkg::CFG_FUNCTION:  exp_function = cfg_ch.data[6:0];
                    mbrc_pkg::CFG_REGISTERS: exp_registers = cfg_ch.data[6:0];
                    default: ;
                endcase
            end
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (reg_write_q.size() > 0) begin
                    w = reg_write_q.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= w.index;
                    cfg_ch.data <= w.data;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        mbrc_pkg::t_result want;
        int                next_wait;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            next_wait = (rx_wait > 0) ? rx_wait - 1 : 0;
            if (out_ch.valid && out_ch.ready) begin
                results_checked++;
                if (payload_status_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 1, 0);
                end else begin
                    want = payload_status_q.pop_front();
                    if (out_ch.payload_valid !== want.payload_valid)
                        report_mismatch("payload_valid", int'(out_ch.payload_valid),
                                        int'(want.payload_valid));
                    if (out_ch.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", int'(out_ch.payload_byte),
                                        int'(want.payload_byte));
                    if (out_ch.frame_done !== want.frame_done)
                        report_mismatch("frame_done", int'(out_ch.frame_done),
                                        int'(want.frame_done));
                    if (out_ch.frame_status !== want.frame_status)
                        report_mismatch("frame_status", int'(out_ch.frame_status),
                                        int'(want.frame_status));
                    if (want.payload_valid) payload_seen++;
                    if (want.frame_done) status_seen[want.frame_status]++;
                end
                next_wait = pick_delay(rx_gap_max);
            end
            rx_wait <= next_wait;
            out_ch.ready <= (next_wait == 0) && !rx_hold;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, payload_status_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (rx_byte_q.size() != 0 || in_ch.valid || payload_status_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_registers(input logic [7:0] slave, input logic [7:0] func_data,
                                 input logic [7:0] regs_data);
        t_reg_write w;
        wait_idle();
        w.index = mbrc_pkg::CFG_SLAVE;
        w.data  = slave;
        reg_write_q.push_back(w);
        w.index = mbrc_pkg::CFG_FUNCTION;
        w.data  = func_data;
        reg_write_q.push_back(w);
        w.index = mbrc_pkg::CFG_REGISTERS;
        w.data  = regs_data;
        reg_write_q.push_back(w);
        do @(negedge i_clk);
        while (reg_write_q.size() != 0 || cfg_ch.valid);
        settings_used++;
    endtask

    task automatic send_frame(input logic [7:0] body[$]);
        t_rx_item item;
        foreach (body[i]) begin
            item.data = body[i];
            item.last = (i == body.size() - 1);
            rx_byte_q.push_back(item);
        end
        frames_queued++;
        stim_bytes += body.size();
    endtask

    task automatic push_frame(input t_frame_kind kind, input int extra);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          n_data;
        int          len;
        n_data = 2 * exp_registers;
        fb.push_back(exp_slave);
        fb.push_back({1'b0, exp_function});
        fb.push_back(8'(n_data));
        if (kind == FR_NOISE) begin
            fb = {};
            repeat ($urandom_range(2, 12)) fb.push_back(8'($urandom));
        end else if (kind == FR_SHORT || kind == FR_LONG) begin
            len = (kind == FR_SHORT) ? $urandom_range(1, 4) : $urandom_range(257, 280);
            while (fb.size() < len) fb.push_back(8'($urandom));
            while (fb.size() > len) void'(fb.pop_back());
        end else begin
            repeat (n_data) fb.push_back(8'($urandom));
            if (kind == FR_EXTRA) begin
                repeat ((extra > 0) ? extra : $urandom_range(1, 4)) fb.push_back(8'($urandom));
            end
            if (kind == FR_CUT && fb.size() > 3) begin
                len = $urandom_range(3, fb.size() - 1);
                while (fb.size() > len) void'(fb.pop_back());
            end
            case (kind)
                FR_BAD_SLAVE: fb[0] ^= 8'($urandom_range(1, 255));
                FR_BAD_FUNC:  fb[1] ^= 8'($urandom_range(1, 255));
                FR_BAD_COUNT: fb[2] ^= 8'($urandom_range(1, 255));
                default: ;
            endcase
            crc = frame_crc(fb);
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            if (kind == FR_BAD_CRC) begin
                len = $urandom_range(0, fb.size() - 1);
                fb[len] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        send_frame(fb);
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return FR_GOOD;
        if (r < 58) return FR_BAD_CRC;
        if (r < 63) return FR_BAD_SLAVE;
        if (r < 68) return FR_BAD_FUNC;
        if (r < 73) return FR_BAD_COUNT;
        if (r < 79) return FR_SHORT;
        if (r < 86) return FR_CUT;
        if (r < 93) return FR_EXTRA;
        if (r < 99) return FR_NOISE;
        return FR_LONG;
    endfunction

    initial begin
        logic [7:0]  fb[$];
        logic [15:0] crc;
        logic [6:0]  regs;
        int          random_start;
        int          n_frames;
        bit          held;
        held = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.end_of_frame = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mbrc_pkg::CFG_SLAVE;
        cfg_ch.data = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: a good frame carrying the payload extremes, one- and four-byte
        // frames, then a corrupted CRC and a wrong function code.
        fb = {};
        fb.push_back(mbrc_pkg::RST_SLAVE);
        fb.push_back({1'b0, mbrc_pkg::RST_FUNCTION});
        fb.push_back({mbrc_pkg::RST_REGISTERS, 1'b0});
        fb.push_back(8'h00);
        fb.push_back(8'hFF);
        crc = frame_crc(fb);
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        send_frame(fb);
        fb = {};
        fb.push_back(8'hFF);
        send_frame(fb);
        fb = {};
        fb.push_back(8'h01);
        fb.push_back(8'h03);
        fb.push_back(8'h02);
        fb.push_back(8'h55);
        send_frame(fb);
        push_frame(FR_BAD_CRC, 0);
        push_frame(FR_BAD_FUNC, 0);

        // Zero registers: a five-byte frame is complete and nothing is released.
        set_registers(8'h00, 8'h00, 8'h00);
        tx_gap_max = 18;
        rx_gap_max = 18;
        push_frame(FR_GOOD, 0);
        push_frame(FR_EXTRA, 0);
        push_frame(FR_BAD_COUNT, 0);
        push_frame(FR_SHORT, 0);

        // All-ones data: function and register count are masked to seven bits.
        set_registers(8'hFF, 8'hFF, 8'hFF);
        tx_gap_max = 3;
        rx_gap_max = 3;
        push_frame(FR_SHORT, 0);
        push_frame(FR_NOISE, 0);

        // Largest legal count: frames of 255, 256 and 257 bytes around the length limit.
        set_registers(8'd247, 8'h03, 8'd125);
        push_frame(FR_GOOD, 0);
        push_frame(FR_EXTRA, 1);
        push_frame(FR_EXTRA, 2);

        random_start = stim_bytes;
        while (stim_bytes - random_start < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0:       regs = 7'd0;
                1:       regs = 7'($urandom_range(9, 20));
                default: regs = 7'($urandom_range(1, 6));
            endcase
            set_registers(8'($urandom), 8'($urandom), {1'($urandom), regs});
            case ($urandom_range(0, 3))
                0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
                1: begin tx_gap_max = 18; rx_gap_max = 0;  end
                2: begin tx_gap_max = 0;  rx_gap_max = 18; end
                default: begin tx_gap_max = 18; rx_gap_max = 18; end
            endcase
            if (!held) begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end
            n_frames = $urandom_range(3, 8);
            repeat (n_frames) push_frame(pick_kind(), 0);
            if (!held) begin
                // Back-pressure: the sender keeps offering while the result side stalls.
                rx_hold = 1'b1;
                repeat (80) @(negedge i_clk);
                rx_hold = 1'b0;
                held = 1'b1;
            end
        end

        wait_idle();
        repeat (4) @(negedge i_clk);
        $display("%0d bytes in %0d frames under %0d register settings, %0d results checked",
                 bytes_accepted, frames_queued, settings_used, results_checked);
        $display("%0d payload bytes; frame status ok %0d, crc %0d, header %0d, length %0d",
                 payload_seen, status_seen[mbrc_pkg::ST_OK], status_seen[mbrc_pkg::ST_CRC_BAD],
                 status_seen[mbrc_pkg::ST_HDR_BAD], status_seen[mbrc_pkg::ST_BAD_LEN]);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
